// ===== design/slbm_pkg.sv =====
package slbm_pkg;

	// Fixed field widths
	localparam int OP_W    = 2;
	localparam int ADDR_W  = 16;
	localparam int DATA_W  = 8;
	localparam int MADDR_W = 19;
	localparam int TGT_W   = 2;
	localparam int MIR_W   = 2;
	localparam int BANK_W  = 5;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	// Stream packing
	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = TGT_W + 1;

	// Default address widths of the target memories
	localparam int PRG_ADDR_BITS_DEF = 19;
	localparam int CHR_ADDR_BITS_DEF = 17;

	// Bank window offsets
	localparam int PRG_OFS_W = 14;
	localparam int CHR_OFS_W = 12;

	typedef enum logic [OP_W-1:0] {
		OP_PRG_READ  = 2'd0,
		OP_PRG_WRITE = 2'd1,
		OP_CHR_READ  = 2'd2,
		OP_CHR_WRITE = 2'd3
	} op_t;

	typedef enum logic [TGT_W-1:0] {
		TGT_NONE    = 2'd0,
		TGT_PRG_ROM = 2'd1,
		TGT_CHR_ROM = 2'd2,
		TGT_CHR_RAM = 2'd3
	} target_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRG_BANK_MASK = 2'd0,
		CFG_CHR_BANK_MASK = 2'd1,
		CFG_CHR_IS_RAM    = 2'd2,
		CFG_UNUSED        = 2'd3
	} cfg_idx_t;

	// Serial register destination, from CPU address bits 14:13
	typedef enum logic [1:0] {
		DST_CONTROL = 2'd0,
		DST_CHR0    = 2'd1,
		DST_CHR1    = 2'd2,
		DST_PRG     = 2'd3
	} dest_t;

	localparam logic [MIR_W-1:0]  MIRROR_RESET   = 2'd3;
	localparam logic [1:0]        PRG_MODE_RESET = 2'd3;
	localparam logic [BANK_W-1:0] CHR_HIGH_RESET = 5'd1;
	localparam logic [2:0]        SHIFT_LAST     = 3'd4;

endpackage

// ===== design/serial_loaded_bank_mapper.sv =====
// Channel   Direction  Handshake              Payload
// s_*       in         s_tvalid / s_tready    tuser: op; tdata: addr, data
// m_*       out        m_tvalid / m_tready    tuser: mem_target, write_enable;
//                                             tdata: mem_addr, write_data, mirroring
// cfg_*     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle while results are taken; each result appears in the cycle after its request is taken.
// Translation and the serial register update are done in the accept cycle, so
// the next request sees the updated mapper state with no bubble.
// The output register doubles as the skid stage: a new request is taken when no result
// is held or the held result is consumed in the same cycle; otherwise s_tready drops.
// arst_n clears the mapper state to its power-on values and empties the output.
module serial_loaded_bank_mapper #(
	parameter int PRG_ADDR_BITS = slbm_pkg::PRG_ADDR_BITS_DEF,
	parameter int CHR_ADDR_BITS = slbm_pkg::CHR_ADDR_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// request stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [slbm_pkg::S_TDATA_W-1:0]   s_tdata,  // [15:0] addr, [23:16] data
	input  logic [slbm_pkg::S_TUSER_W-1:0]   s_tuser,  // [1:0] op
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [slbm_pkg::M_TDATA_W-1:0]   m_tdata,  // [18:0] mem_addr, [26:19] write_data,
	                                                   // [28:27] mirroring, [31:29] zero
	output logic [slbm_pkg::M_TUSER_W-1:0]   m_tuser,  // [1:0] mem_target, [2] write_enable
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [slbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [slbm_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import slbm_pkg::*;

	// Address masks for the two target memories
	localparam logic [MADDR_W-1:0] PRG_MASK = MADDR_W'((64'd1 << PRG_ADDR_BITS) - 64'd1);
	localparam logic [MADDR_W-1:0] CHR_MASK = MADDR_W'((64'd1 << CHR_ADDR_BITS) - 64'd1);

	// Configuration registers
	logic [BANK_W-1:0] prg_bank_mask_q;
	logic [BANK_W-1:0] chr_bank_mask_q;
	logic              chr_is_ram_q;

	// Mapper state
	logic [BANK_W-1:0] shift_value_q;
	logic [2:0]        shift_count_q;
	logic [MIR_W-1:0]  mirror_mode_q;
	logic              chr_mode_q;
	logic [1:0]        prg_mode_q;
	logic [3:0]        prg_bank_q;
	logic [BANK_W-1:0] chr_bank_low_q;
	logic [BANK_W-1:0] chr_bank_high_q;

	// Result register
	logic               out_valid_q;
	logic [MADDR_W-1:0] mem_addr_q;
	target_t            mem_target_q;
	logic               write_enable_q;
	logic [DATA_W-1:0]  write_data_q;
	logic [MIR_W-1:0]   mirroring_q;

	// Request fields
	op_t               op;
	logic [ADDR_W-1:0] addr;
	logic [DATA_W-1:0] data;
	logic              accept;

	assign op   = op_t'(s_tuser);
	assign addr = s_tdata[ADDR_W-1:0];
	assign data = s_tdata[ADDR_W +: DATA_W];

	// Take a request whenever the held result leaves this cycle or none is held
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// PRG bank selection
	logic              prg_upper;
	logic [BANK_W-1:0] prg_bank_ext;
	logic [BANK_W-1:0] prg_bank_sel;
	logic [MADDR_W-1:0] prg_addr;

	assign prg_upper    = addr[PRG_OFS_W];
	assign prg_bank_ext = {1'b0, prg_bank_q};

	always_comb begin
		case (prg_mode_q)
			2'd0, 2'd1: prg_bank_sel = prg_upper ? (prg_bank_ext | 5'd1) : (prg_bank_ext & 5'h0E);
			2'd2:       prg_bank_sel = prg_upper ? prg_bank_ext : '0;
			default:    prg_bank_sel = prg_upper ? prg_bank_mask_q : prg_bank_ext;
		endcase
	end

	assign prg_addr = {prg_bank_sel & prg_bank_mask_q, addr[PRG_OFS_W-1:0]} & PRG_MASK;

	// CHR bank selection
	logic              chr_upper;
	logic [BANK_W-1:0] chr_bank_sel;
	logic [MADDR_W-1:0] chr_addr;

	assign chr_upper = addr[CHR_OFS_W];

	always_comb begin
		if (!chr_mode_q) begin
			// 8K mode: even/odd pair around chr_bank_low
			chr_bank_sel = chr_upper ? (chr_bank_low_q | 5'd1) : (chr_bank_low_q & 5'h1E);
		end else begin
			chr_bank_sel = chr_upper ? chr_bank_high_q : chr_bank_low_q;
		end
	end

	assign chr_addr = MADDR_W'({chr_bank_sel & chr_bank_mask_q, addr[CHR_OFS_W-1:0]}) & CHR_MASK;

	// Window checks
	logic cpu_window;
	logic ppu_window;

	assign cpu_window = addr[ADDR_W-1];
	assign ppu_window = (addr[ADDR_W-1:13] == 3'd0);

	// Result for this request
	logic [MADDR_W-1:0] res_addr;
	target_t            res_target;
	logic               res_we;
	logic [DATA_W-1:0]  res_wd;

	always_comb begin
		res_addr   = '0;
		res_target = TGT_NONE;
		res_we     = 1'b0;
		res_wd     = '0;
		case (op)
			OP_PRG_READ: begin
				if (cpu_window) begin
					res_addr   = prg_addr;
					res_target = TGT_PRG_ROM;
				end
			end
			OP_PRG_WRITE: begin
				// register load, no memory access
			end
			default: begin
				if (ppu_window) begin
					if (chr_is_ram_q) begin
						res_addr   = MADDR_W'(addr[12:0]);
						res_target = TGT_CHR_RAM;
						if (op == OP_CHR_WRITE) begin
							res_we = 1'b1;
							res_wd = data;
						end
					end else if (op == OP_CHR_READ) begin
						res_addr   = chr_addr;
						res_target = TGT_CHR_ROM;
					end
				end
			end
		endcase
	end

	// Serial register load
	logic              reg_write;
	logic              load_reset;
	logic              commit;
	logic [BANK_W-1:0] shift_next;
	dest_t             dest;

	assign reg_write  = accept && (op == OP_PRG_WRITE) && cpu_window;
	assign load_reset = data[7];
	assign commit     = !load_reset && (shift_count_q == SHIFT_LAST);
	assign shift_next = {data[0], shift_value_q[BANK_W-1:1]};
	assign dest       = dest_t'(addr[14:13]);

	// Mirroring reported with the result is the value after this request's update
	logic [MIR_W-1:0] mirror_next;

	assign mirror_next = (reg_write && commit && dest == DST_CONTROL) ?
	                     shift_next[1:0] : mirror_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_mask_q <= '1;
			chr_bank_mask_q <= '1;
			chr_is_ram_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_PRG_BANK_MASK: prg_bank_mask_q <= cfg_data;
				CFG_CHR_BANK_MASK: chr_bank_mask_q <= cfg_data;
				CFG_CHR_IS_RAM:    chr_is_ram_q    <= cfg_data[0];
				default: begin
					// no register there, drop the write
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_value_q   <= '0;
			shift_count_q   <= '0;
			mirror_mode_q   <= MIRROR_RESET;
			chr_mode_q      <= 1'b0;
			prg_mode_q      <= PRG_MODE_RESET;
			prg_bank_q      <= '0;
			chr_bank_low_q  <= '0;
			chr_bank_high_q <= CHR_HIGH_RESET;
		end else if (reg_write) begin
			if (load_reset) begin
				// clear the shift register and lock the last bank at 0xC000
				shift_value_q <= '0;
				shift_count_q <= '0;
				prg_mode_q    <= PRG_MODE_RESET;
			end else if (commit) begin
				shift_value_q <= '0;
				shift_count_q <= '0;
				case (dest)
					DST_CONTROL: begin
						mirror_mode_q <= shift_next[1:0];
						prg_mode_q    <= shift_next[3:2];
						chr_mode_q    <= shift_next[4];
					end
					DST_CHR0: chr_bank_low_q  <= shift_next;
					DST_CHR1: chr_bank_high_q <= shift_next;
					default:  prg_bank_q      <= shift_next[3:0];
				endcase
			end else begin
				shift_value_q <= shift_next;
				shift_count_q <= shift_count_q + 3'd1;
			end
		end
	end

	// Result register: load on accept, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mem_addr_q     <= res_addr;
			mem_target_q   <= res_target;
			write_enable_q <= res_we;
			write_data_q   <= res_wd;
			mirroring_q    <= mirror_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, mirroring_q, write_data_q, mem_addr_q};
	assign m_tuser  = {write_enable_q, mem_target_q};

endmodule
